// ----- hw/rtl/uqd_pkg.sv -----
// Shared types, character codes and helpers for the URL query decoder.
// No dependencies; imported by every module of the decoder.
package uqd_pkg;

    localparam int unsigned UQD_OUTQ_DEPTH = 4;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CTRL_MAX = 8'h1F;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [15:0] MAX_PART_LEN_RST = 16'd2047;
    localparam logic [4:0]  HEX_BAD          = 5'd16;

    // Register indexes on the configuration port
    localparam logic REG_KEEP_NL = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    typedef enum logic [2:0] {
        K_NAME_BYTE  = 3'd0,
        K_VALUE_BYTE = 3'd1,
        K_NAME_END   = 3'd2,
        K_FIELD_END  = 3'd3,
        K_OK         = 3'd4,
        K_FAILED     = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        PH_NAME  = 4'b0001,
        PH_VALUE = 4'b0010,
        PH_SKIP  = 4'b0100,
        PH_FAIL  = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_HI   = 3'b010,
        ESC_LO   = 3'b100
    } t_esc;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_res;

    // Up to two results per input item; the second only ever follows the first
    typedef struct packed {
        logic v0;
        t_res r0;
        logic v1;
        t_res r1;
    } t_push;

    typedef struct packed {
        logic        keep_newlines;
        logic [15:0] max_part_len;
    } t_cfg;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_BAD;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0]} + 5'd9;
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/uqd_regs.sv -----
// APB-style configuration registers of the URL query decoder.
// Depends on uqd_pkg.
module uqd_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output uqd_pkg::t_cfg o_cfg
);
    import uqd_pkg::*;

    logic r_keep_nl;
    logic [15:0] r_max_len;
    logic wr_en;
    logic reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_nl <= 1'b0;
            r_max_len <= MAX_PART_LEN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KEEP_NL: r_keep_nl <= pwdata[0];
                REG_MAX_LEN: r_max_len <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEEP_NL: prdata = {31'd0, r_keep_nl};
            REG_MAX_LEN: prdata = {16'd0, r_max_len};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{keep_newlines: r_keep_nl, max_part_len: r_max_len};

endmodule

// ----- hw/rtl/uqd_decode.sv -----
// Query parse state and single-pass byte decode; produces up to two results
// per accepted item. Depends on uqd_pkg.
module uqd_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  uqd_pkg::t_cfg  i_cfg,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    input  logic           i_end_of_query,
    output uqd_pkg::t_push o_push
);
    import uqd_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_at_start, n_at_start;
    t_esc        r_esc, n_esc;
    logic [4:0]  r_high, n_high;
    logic [15:0] r_part_count, n_part_count;

    t_push       push;
    logic        do_decode;
    t_kind       dec_kind;
    logic [16:0] cnt;
    logic [4:0]  hv;
    logic [7:0]  pair;

    assign cnt  = {1'b0, r_part_count} + 17'd1;
    assign hv   = hex_val(i_in_byte);
    assign pair = {r_high[3:0], hv[3:0]};

    always_comb begin
        n_phase      = r_phase;
        n_at_start   = r_at_start;
        n_esc        = r_esc;
        n_high       = r_high;
        n_part_count = r_part_count;
        push         = '0;
        do_decode    = 1'b0;
        dec_kind     = K_NAME_BYTE;

        if (i_end_of_query) begin
            push.v0      = 1'b1;
            push.r0.last = 1'b1;
            push.r0.kind = K_OK;
            case (r_phase)
                PH_FAIL: push.r0.kind = K_FAILED;
                PH_NAME: if (!r_at_start) push.r0.kind = K_FAILED;
                PH_VALUE: begin
                    if (r_part_count >= i_cfg.max_part_len) begin
                        push.r0.kind = K_FAILED;
                    end else begin
                        push.r0.kind = K_FIELD_END;
                        push.r0.last = 1'b0;
                        push.v1      = 1'b1;
                        push.r1.kind = K_OK;
                        push.r1.last = 1'b1;
                    end
                end
                default: ;
            endcase
            n_phase      = PH_NAME;
            n_at_start   = 1'b1;
            n_esc        = ESC_IDLE;
            n_high       = 5'd0;
            n_part_count = 16'd0;
        end else begin
            case (r_phase)
                PH_NAME: begin
                    if (i_in_byte == CH_AMP) begin
                        if (!r_at_start) n_phase = PH_FAIL;
                        n_esc        = ESC_IDLE;
                        n_high       = 5'd0;
                        n_part_count = 16'd0;
                    end else if (i_in_byte == CH_EQ) begin
                        if (r_at_start) begin
                            n_phase = PH_SKIP;
                        end else begin
                            push.v0      = 1'b1;
                            push.r0.kind = K_NAME_END;
                            n_phase      = PH_VALUE;
                        end
                        n_at_start   = 1'b0;
                        n_esc        = ESC_IDLE;
                        n_high       = 5'd0;
                        n_part_count = 16'd0;
                    end else begin
                        n_at_start = 1'b0;
                        do_decode  = 1'b1;
                        dec_kind   = K_NAME_BYTE;
                    end
                end
                PH_VALUE: begin
                    if (i_in_byte == CH_AMP) begin
                        if (r_part_count >= i_cfg.max_part_len) begin
                            n_phase = PH_FAIL;
                        end else begin
                            push.v0      = 1'b1;
                            push.r0.kind = K_FIELD_END;
                            n_phase      = PH_NAME;
                            n_at_start   = 1'b1;
                        end
                        n_esc        = ESC_IDLE;
                        n_high       = 5'd0;
                        n_part_count = 16'd0;
                    end else begin
                        do_decode = 1'b1;
                        dec_kind  = K_VALUE_BYTE;
                    end
                end
                PH_SKIP: begin
                    if (i_in_byte == CH_AMP) begin
                        n_phase      = PH_NAME;
                        n_at_start   = 1'b1;
                        n_esc        = ESC_IDLE;
                        n_high       = 5'd0;
                        n_part_count = 16'd0;
                    end
                end
                default: ;
            endcase
        end

        // Counted byte of a name or value
        if (do_decode) begin
            n_part_count = cnt[15:0];
            push.r0.kind = dec_kind;
            if (cnt >= {1'b0, i_cfg.max_part_len}) begin
                n_phase = PH_FAIL;
            end else begin
                case (r_esc)
                    ESC_HI: begin
                        n_high = hv;
                        n_esc  = ESC_LO;
                    end
                    ESC_LO: begin
                        n_esc  = ESC_IDLE;
                        n_high = 5'd0;
                        // drop bad pairs and pairs that decode to control codes
                        if (r_high != HEX_BAD && hv != HEX_BAD && pair > CTRL_MAX) begin
                            push.v0      = 1'b1;
                            push.r0.data = pair;
                        end
                    end
                    default: begin
                        if (i_in_byte == CH_PCT) begin
                            n_esc = ESC_HI;
                        end else if (i_in_byte == CH_PLUS) begin
                            push.v0      = 1'b1;
                            push.r0.data = CH_SPACE;
                        end else if (i_in_byte <= CTRL_MAX) begin
                            if (i_cfg.keep_newlines &&
                                (i_in_byte == CH_LF || i_in_byte == CH_CR)) begin
                                push.v0      = 1'b1;
                                push.r0.data = i_in_byte;
                            end
                        end else begin
                            push.v0      = 1'b1;
                            push.r0.data = i_in_byte;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NAME;
            r_at_start   <= 1'b1;
            r_esc        <= ESC_IDLE;
            r_high       <= 5'd0;
            r_part_count <= 16'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_at_start   <= n_at_start;
            r_esc        <= n_esc;
            r_high       <= n_high;
            r_part_count <= n_part_count;
        end
    end

    always_comb begin
        o_push    = push;
        o_push.v0 = push.v0 & i_accept;
        o_push.v1 = push.v1 & i_accept;
    end

endmodule

// ----- hw/rtl/uqd_outq.sv -----
// Small result queue between the decoder and the output channel; takes up
// to two results per cycle and hands out one. Depends on uqd_pkg.
module uqd_outq #(
    parameter int unsigned DEPTH = uqd_pkg::UQD_OUTQ_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  uqd_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output uqd_pkg::t_res  o_res
);
    import uqd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + PW'(1);
    endfunction

    t_res          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] wr_next;
    logic          pop;

    assign wr_next = ptr_inc(r_wr);
    assign pop     = o_valid & i_ready;
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= ROOM_MAX);
    assign o_res   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.v0) n_wr = wr_next;
        if (i_push.v1) n_wr = ptr_inc(wr_next);
        if (pop) n_rd = ptr_inc(r_rd);
        n_count = r_count + CW'(i_push.v0) + CW'(i_push.v1) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr] <= i_push.r0;
        if (i_push.v1) r_mem[wr_next] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- hw/rtl/url_query_decoder_unit.sv -----
// URL query decoder: percent/plus decoding of query bytes into a tagged stream.
// A result is queued by the transfer that causes it, behind earlier results.
// Throughput: one input transfer per cycle; the result queue of OUTQ_DEPTH
// entries takes input while it has room for the two results of one item.
// Reset (synchronous, active low) clears parse state, the result queue and
// the registers (keep_newlines 0, max_part_len 2047). Depends on uqd_pkg.
module url_query_decoder_unit #(
    parameter int unsigned OUTQ_DEPTH = uqd_pkg::UQD_OUTQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_query,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_out_kind,
    output logic        o_out_last
);
    import uqd_pkg::*;

    t_cfg  cfg;
    t_push push;
    t_res  res;
    logic  room;
    logic  accept;

    assign o_in_ready = room;
    assign accept     = i_in_valid & room;

    uqd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    uqd_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_query (i_end_of_query),
        .o_push         (push)
    );

    uqd_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res)
    );

    assign o_out_byte = res.data;
    assign o_out_kind = res.kind;
    assign o_out_last = res.last;

endmodule
